// File: hw/rtl/ils_pkg.sv
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int ILS_CAPACITY    = 64;
    localparam int ILS_VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_HEAD   = 3'd1,
        MODE_TAIL   = 3'd2,
        MODE_AT     = 3'd3,
        MODE_DELETE = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

endpackage

// File: hw/rtl/ils_cell.sv
// One storage cell of the list chain: holds one entry and shifts with its neighbours.
module ils_cell #(
    parameter int INDEX       = 0,
    parameter int POS_WIDTH   = 7,
    parameter int VALUE_WIDTH = ils_pkg::ILS_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  ils_pkg::t_cell_op      i_op,
    input  logic [POS_WIDTH-1:0]   i_pos,
    input  logic [VALUE_WIDTH-1:0] i_data,
    input  logic [VALUE_WIDTH-1:0] i_prev,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_rd
);

    localparam logic [POS_WIDTH-1:0] Idx = POS_WIDTH'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_op)
            ils_pkg::CELL_INS: begin
                // cells above the gap take their lower neighbour
                if (Idx > i_pos) begin
                    r_value <= i_prev;
                end else if (Idx == i_pos) begin
                    r_value <= i_data;
                end
            end
            ils_pkg::CELL_DEL: begin
                if (Idx >= i_pos) begin
                    r_value <= i_next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_value = r_value;
    assign o_rd    = (Idx == i_pos) ? r_value : '0;

endmodule

// File: hw/rtl/ils_ctrl.sv
// Request decode, entry count, handshake and result register for the list store.
module ils_ctrl #(
    parameter int CAPACITY    = ils_pkg::ILS_CAPACITY,
    parameter int VALUE_WIDTH = ils_pkg::ILS_VALUE_WIDTH,
    parameter int POS_WIDTH   = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_mode,
    input  logic [POS_WIDTH-1:0]   i_position,
    input  logic [VALUE_WIDTH-1:0] i_rd_data,
    output ils_pkg::t_cell_op      o_cell_op,
    output logic [POS_WIDTH-1:0]   o_cell_pos,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_read_value,
    output logic                   o_hit,
    output logic [1:0]             o_status,
    output logic [POS_WIDTH-1:0]   o_list_length
);

    localparam logic [POS_WIDTH-1:0] Cap = POS_WIDTH'(CAPACITY);

    logic [POS_WIDTH-1:0]   r_count;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_read_value;
    logic                   r_hit;
    ils_pkg::t_status       r_status;

    logic [POS_WIDTH-1:0]   n_count;
    logic [VALUE_WIDTH-1:0] n_read_value;
    logic                   n_hit;
    ils_pkg::t_status       n_status;
    ils_pkg::t_cell_op      n_op;
    logic [POS_WIDTH-1:0]   n_pos;
    logic                   accept;
    logic                   full;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == Cap);

    always_comb begin
        n_read_value = '0;
        n_hit        = 1'b0;
        n_status     = ils_pkg::ST_DONE;
        n_op         = ils_pkg::CELL_HOLD;
        n_pos        = i_position;
        case (ils_pkg::t_mode'(i_mode))
            ils_pkg::MODE_READ: begin
                if (i_position < r_count) begin
                    n_read_value = i_rd_data;
                    n_hit        = 1'b1;
                end else begin
                    n_read_value = '1;
                    n_status     = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::MODE_HEAD, ils_pkg::MODE_TAIL: begin
                n_pos = (ils_pkg::t_mode'(i_mode) == ils_pkg::MODE_HEAD) ? '0 : r_count;
                if (full) begin
                    n_status = ils_pkg::ST_FULL;
                end else begin
                    n_op = ils_pkg::CELL_INS;
                end
            end
            ils_pkg::MODE_AT: begin
                // range check takes precedence over the full check
                if (i_position > r_count) begin
                    n_status = ils_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = ils_pkg::ST_FULL;
                end else begin
                    n_op = ils_pkg::CELL_INS;
                end
            end
            ils_pkg::MODE_DELETE: begin
                if (i_position >= r_count) begin
                    n_status = ils_pkg::ST_RANGE;
                end else begin
                    n_op = ils_pkg::CELL_DEL;
                end
            end
            default: begin
                n_status = ils_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb begin
        case (n_op)
            ils_pkg::CELL_INS: n_count = r_count + POS_WIDTH'(1);
            ils_pkg::CELL_DEL: n_count = r_count - POS_WIDTH'(1);
            default:           n_count = r_count;
        endcase
    end

    assign o_cell_op  = accept ? n_op : ils_pkg::CELL_HOLD;
    assign o_cell_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_hit        <= n_hit;
            r_status     <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_hit         = r_hit;
    assign o_status      = r_status;
    assign o_list_length = r_count;

endmodule

// File: hw/rtl/indexed_list_store.sv
// Top level of the indexed list store: control unit and chain of entry cells.
// A result is registered when its request transfers and is presented in the cycle after.
// Throughput: one request per cycle unless a held result stalls the input; an insert or delete
// shifts the cells from its position up at the transfer, and a read selects its cell the same cycle.
// Reset clears the entry count and the result valid; cell contents are left
// undefined and are never read before being written.
module indexed_list_store #(
    parameter int CAPACITY    = ils_pkg::ILS_CAPACITY,
    parameter int VALUE_WIDTH = ils_pkg::ILS_VALUE_WIDTH,
    parameter int POS_WIDTH   = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_mode,
    input  logic [POS_WIDTH-1:0]   i_position,
    input  logic [VALUE_WIDTH-1:0] i_item_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_read_value,
    output logic                   o_hit,
    output logic [1:0]             o_status,
    output logic [POS_WIDTH-1:0]   o_list_length
);

    ils_pkg::t_cell_op      cell_op;
    logic [POS_WIDTH-1:0]   cell_pos;
    logic [VALUE_WIDTH-1:0] cell_q  [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_rd [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data;

    ils_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .POS_WIDTH   (POS_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_rd_data     (rd_data),
        .o_cell_op     (cell_op),
        .o_cell_pos    (cell_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_hit         (o_hit),
        .o_status      (o_status),
        .o_list_length (o_list_length)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_q;
        logic [VALUE_WIDTH-1:0] next_q;

        // chain ends: head never takes from below, tail holds its own value
        if (k == 0) begin : g_head
            assign prev_q = i_item_value;
        end else begin : g_mid_lo
            assign prev_q = cell_q[k-1];
        end
        if (k == CAPACITY - 1) begin : g_tail
            assign next_q = cell_q[k];
        end else begin : g_mid_hi
            assign next_q = cell_q[k+1];
        end

        ils_cell #(
            .INDEX       (k),
            .POS_WIDTH   (POS_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_pos   (cell_pos),
            .i_data  (i_item_value),
            .i_prev  (prev_q),
            .i_next  (next_q),
            .o_value (cell_q[k]),
            .o_rd    (cell_rd[k])
        );
    end

    // only the addressed cell drives non-zero read data
    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_data = rd_data | cell_rd[k];
        end
    end

endmodule

// File: hw/rtl/ils_checker.sv
// Port-level checker for the indexed list store, bound to the top level.
module ils_checker #(
    parameter int CAPACITY    = ils_pkg::ILS_CAPACITY,
    parameter int VALUE_WIDTH = ils_pkg::ILS_VALUE_WIDTH,
    parameter int POS_WIDTH   = $clog2(CAPACITY + 1)
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [VALUE_WIDTH-1:0] o_read_value,
    input logic                   o_hit,
    input logic [1:0]             o_status,
    input logic [POS_WIDTH-1:0]   o_list_length
);

    localparam logic [POS_WIDTH-1:0] Cap = POS_WIDTH'(CAPACITY);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_status == ils_pkg::ST_DONE)
        else $error("hit with non-done status");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ils_pkg::ST_FULL |-> o_list_length == Cap)
        else $error("full status while store not full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_status) && $stable(o_list_length))
        else $error("stalled result changed");

endmodule

bind indexed_list_store ils_checker #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .POS_WIDTH   (POS_WIDTH)
) u_ils_checker (.*);

// File: test/ils_checker.sv
// Scoreboard for the indexed list store: mirrors the list and checks each result.
`timescale 1ns / 1ps
module ils_scoreboard (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    input  logic                                        i_in_ready,
    input  logic [2:0]                                  i_mode,
    input  logic [$clog2(ils_pkg::ILS_CAPACITY + 1)-1:0] i_position,
    input  logic [ils_pkg::ILS_VALUE_WIDTH-1:0]         i_item_value,
    input  logic                                        i_out_valid,
    input  logic                                        i_out_ready,
    input  logic [ils_pkg::ILS_VALUE_WIDTH-1:0]         i_read_value,
    input  logic                                        i_hit,
    input  logic [1:0]                                  i_status,
    input  logic [$clog2(ils_pkg::ILS_CAPACITY + 1)-1:0] i_list_length,
    output int                                          o_fail_count,
    output int                                          o_pending,
    output int                                          o_list_length
);

    localparam int LEN_W = $clog2(ils_pkg::ILS_CAPACITY + 1);

    typedef struct packed {
        logic [ils_pkg::ILS_VALUE_WIDTH-1:0] read_value;
        logic                                hit;
        ils_pkg::t_status                    status;
        logic [LEN_W-1:0]                    list_length;
    } t_list_result;

    logic [ils_pkg::ILS_VALUE_WIDTH-1:0] list_cells [ils_pkg::ILS_CAPACITY];
    int                                  list_entries;
    t_list_result                        awaited_results [$];

    // Apply one request to the mirrored list and return the result it gives.
    function automatic t_list_result apply_request(input logic [2:0] req_mode, input int pos,
                                                   input logic [ils_pkg::ILS_VALUE_WIDTH-1:0] value);
        t_list_result res;
        int           slot;
        res.read_value  = '0;
        res.hit         = 1'b0;
        res.status      = ils_pkg::ST_DONE;
        res.list_length = '0;
        slot            = -1;
        case (req_mode)
            ils_pkg::MODE_READ: begin
                if (pos < list_entries) begin
                    res.read_value = list_cells[pos];
                    res.hit        = 1'b1;
                end else begin
                    res.read_value = '1;
                    res.status     = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::MODE_HEAD, ils_pkg::MODE_TAIL: begin
                if (list_entries >= ils_pkg::ILS_CAPACITY)
                    res.status = ils_pkg::ST_FULL;
                else
                    slot = (req_mode == ils_pkg::MODE_HEAD) ? 0 : list_entries;
            end
            ils_pkg::MODE_AT: begin
                // range check takes priority over the full check
                if (pos > list_entries)
                    res.status = ils_pkg::ST_RANGE;
                else if (list_entries >= ils_pkg::ILS_CAPACITY)
                    res.status = ils_pkg::ST_FULL;
                else
                    slot = pos;
            end
            ils_pkg::MODE_DELETE: begin
                if (pos >= list_entries) begin
                    res.status = ils_pkg::ST_RANGE;
                end else begin
                    for (int k = pos; k < list_entries - 1; k++)
                        list_cells[k] = list_cells[k + 1];
                    list_entries--;
                end
            end
            default: res.status = ils_pkg::ST_RANGE;
        endcase
        if (slot >= 0) begin
            for (int k = list_entries; k > slot; k--)
                list_cells[k] = list_cells[k - 1];
            list_cells[slot] = value;
            list_entries++;
        end
        res.list_length = LEN_W'(list_entries);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            // results are registered behind their requests, so compare before predicting
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               $signed(want.read_value), $signed(i_read_value));
                        o_fail_count++;
                    end
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, i_hit);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_list_length !== want.list_length) begin
                        $error("list_length: expected %0d, actual %0d",
                               want.list_length, i_list_length);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_request(i_mode, int'(i_position), i_item_value));
        end
        o_pending     = awaited_results.size();
        o_list_length = list_entries;
    end

endmodule

// File: test/tb_top.sv
// Top of the indexed list store testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int LEN_W            = $clog2(ils_pkg::ILS_CAPACITY + 1);
    localparam int CAP              = ils_pkg::ILS_CAPACITY;
    localparam int VW               = ils_pkg::ILS_VALUE_WIDTH;
    localparam int MODE_CODE_MAX    = 7;
    localparam int BLOCK_REQUESTS   = 50;
    localparam int RANDOM_BLOCKS    = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 4;

    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIX    = 2;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       in_mode;
    logic [LEN_W-1:0] in_position;
    logic [VW-1:0]    in_item_value;
    logic             out_valid;
    logic             out_ready;
    logic [VW-1:0]    out_read_value;
    logic             out_hit;
    logic [1:0]       out_status;
    logic [LEN_W-1:0] out_list_length;

    int fail_count;
    int pending;
    int model_length;
    bit calm;
    bit hold_off_req;

    indexed_list_store DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (in_mode),
        .i_position    (in_position),
        .i_item_value  (in_item_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_read_value  (out_read_value),
        .o_hit         (out_hit),
        .o_status      (out_status),
        .o_list_length (out_list_length)
    );

    ils_scoreboard u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (in_mode),
        .i_position    (in_position),
        .i_item_value  (in_item_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_read_value  (out_read_value),
        .i_hit         (out_hit),
        .i_status      (out_status),
        .i_list_length (out_list_length),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_list_length (model_length)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // End the run when neither channel has moved for too long.
    always @(posedge clk) begin
        int idle_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // Offer one request and hold it until the transfer; returns on the following falling edge.
    task automatic send_request(input logic [2:0] req_mode, input int pos,
                                input logic [VW-1:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_mode       <= req_mode;
        in_position   <= LEN_W'(pos);
        in_item_value <= value;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(VW - 1){1'b0}}};
            1:       return {1'b0, {(VW - 1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_insert();
        case ($urandom_range(0, 2))
            0:       return ils_pkg::MODE_HEAD;
            1:       return ils_pkg::MODE_TAIL;
            default: return ils_pkg::MODE_AT;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode(input int bias);
        int r;
        int ins_pct;
        int del_pct;
        r       = $urandom_range(0, 99);
        ins_pct = (bias == BIAS_GROW) ? 60 : (bias == BIAS_SHRINK) ? 18 : 35;
        del_pct = (bias == BIAS_GROW) ? 13 : (bias == BIAS_SHRINK) ? 55 : 30;
        if (r < 2)
            return 3'($urandom_range(int'(ils_pkg::MODE_DELETE) + 1, MODE_CODE_MAX));
        else if (r < 2 + ins_pct)
            return pick_insert();
        else if (r < 2 + ins_pct + del_pct)
            return ils_pkg::MODE_DELETE;
        else
            return ils_pkg::MODE_READ;
    endfunction

    // Mostly positions that hit the current list, some at its end, some anywhere.
    function automatic int pick_position(input logic [2:0] req_mode);
        int hi_pos;
        hi_pos = (req_mode == ils_pkg::MODE_AT) ? model_length : model_length - 1;
        case ($urandom_range(0, 9))
            0:       return model_length;
            1:       return $urandom_range(0, CAP);
            default: return (hi_pos < 0) ? $urandom_range(0, CAP)
                                         : $urandom_range(0, hi_pos);
        endcase
    endfunction

    task automatic random_block(input int bias);
        logic [2:0] req_mode;
        for (int n = 0; n < BLOCK_REQUESTS; n++) begin
            req_mode = pick_mode(bias);
            send_request(req_mode, pick_position(req_mode), pick_value());
        end
    endtask

    // Result side: random hold-offs, one long one on request.
    initial begin
        int hold_cycles;
        bit long_hold_done;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_off_req && !long_hold_done) begin
                hold_cycles    = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end else begin
                hold_cycles = calm ? 0 : $urandom_range(0, 7);
            end
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        logic [2:0] req_mode;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_mode       = ils_pkg::MODE_READ;
        in_position   = '0;
        in_item_value = '0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list corner cases
        send_request(ils_pkg::MODE_READ, 0, 32'h0000_0000);
        send_request(ils_pkg::MODE_DELETE, 0, 32'h0000_0000);
        send_request(ils_pkg::MODE_AT, 1, 32'h1234_5678);
        // insert at the length appends
        send_request(ils_pkg::MODE_AT, 0, 32'h7FFF_FFFF);
        send_request(ils_pkg::MODE_HEAD, 0, 32'h8000_0000);
        send_request(ils_pkg::MODE_TAIL, CAP, 32'h0000_0000);
        send_request(ils_pkg::MODE_TAIL, 0, 32'hFFFF_FFFF);
        send_request(ils_pkg::MODE_AT, 2, 32'h5555_5555);
        send_request(ils_pkg::MODE_AT, 5, 32'hAAAA_AAAA);
        // walk the list and one past its end
        for (int k = 0; k <= 6; k++)
            send_request(ils_pkg::MODE_READ, k, 32'h0000_0000);
        send_request(ils_pkg::MODE_READ, CAP, 32'hFFFF_FFFF);
        for (int k = int'(ils_pkg::MODE_DELETE) + 1; k <= MODE_CODE_MAX; k++)
            send_request(3'(k), k, $urandom());
        send_request(ils_pkg::MODE_DELETE, 6, 32'h0000_0000);
        send_request(ils_pkg::MODE_DELETE, 5, 32'h0000_0000);
        send_request(ils_pkg::MODE_DELETE, 0, 32'h0000_0000);
        send_request(ils_pkg::MODE_DELETE, 1, 32'h0000_0000);

        // fill to capacity, then push every insert kind against the full store
        while (model_length < CAP) begin
            req_mode = pick_insert();
            send_request(req_mode, pick_position(req_mode), pick_value());
        end
        send_request(ils_pkg::MODE_HEAD, 0, pick_value());
        send_request(ils_pkg::MODE_TAIL, 0, pick_value());
        send_request(ils_pkg::MODE_AT, CAP, pick_value());
        send_request(ils_pkg::MODE_AT, 0, pick_value());
        send_request(ils_pkg::MODE_READ, CAP - 1, pick_value());
        send_request(ils_pkg::MODE_READ, CAP, pick_value());
        send_request(ils_pkg::MODE_DELETE, CAP, pick_value());

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            calm = (blk % 5 == 3);
            if (blk == 10)
                hold_off_req = 1'b1;
            random_block((blk % 4 == 0) ? BIAS_GROW :
                         (blk % 4 == 2) ? BIAS_SHRINK : BIAS_MIX);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
